FILE: design/sact_pkg.sv
package sact_pkg;

  localparam int unsigned NUM_SETS    = 64;
  localparam int unsigned NUM_WAYS    = 4;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned IDX_W  = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned TAG_W  = ADDR_W - OFF_W - SET_W;

  localparam int unsigned LAT_W  = 10;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned CIDX_W = 2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_CACHE_ENABLE  = 2'd0,
    CFG_HIT_LATENCY   = 2'd1,
    CFG_READ_LATENCY  = 2'd2,
    CFG_WRITE_LATENCY = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [LAT_W-1:0] latency;
    logic             hit;
    logic             writeback;
    logic [CNT_W-1:0] total_reads;
    logic [CNT_W-1:0] total_writes;
    logic [CNT_W-1:0] total_read_misses;
    logic [CNT_W-1:0] total_write_misses;
    logic [CNT_W-1:0] total_writebacks;
  } rsp_t;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0] valid;
    logic [NUM_WAYS-1:0] dirty;
    logic [WAY_W-1:0]    victim;
    tag_row_t            tags;
  } set_row_t;

endpackage

FILE: design/set_assoc_cache_tag_model.sv
// A request beat is registered into stage s1 on acceptance, with its set row read;
//   compare and update then go into the result register that offers the result beat.
// Throughput: one request per cycle unless the output stalls; same-set back-to-back
//   requests included, the set row written by one being forwarded to the next read.
// Reset at once clears set-used flags and counters and sets config defaults; the set
//   memory is not reset and the row of a set never written reads as empty.
module set_assoc_cache_tag_model
  import sact_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_data_o
);

  logic             en_q;
  logic [CFG_W-1:0] hit_lat_q, rd_lat_q, wr_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b1;
      hit_lat_q <= CFG_W'(0);
      rd_lat_q  <= CFG_W'(30);
      wr_lat_q  <= CFG_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CACHE_ENABLE:  en_q      <= cfg_data_i[0];
        CFG_HIT_LATENCY:   hit_lat_q <= cfg_data_i;
        CFG_READ_LATENCY:  rd_lat_q  <= cfg_data_i;
        CFG_WRITE_LATENCY: wr_lat_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q, out_valid_q;
  req_t s1_q;
  rsp_t out_q;
  rsp_t out_d;
  logic in_acc, adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Line state: one memory row per set, a flag marks sets written since reset
  set_row_t            set_mem [NUM_SETS];
  logic [NUM_SETS-1:0] set_used_q;
  logic                row_used_q;
  set_row_t            row_q;
  set_row_t            row_cur;
  set_row_t            row_new;
  logic [CNT_W-1:0]    rd_cnt_q, wr_cnt_q, rd_miss_q, wr_miss_q, wb_cnt_q;
  logic [CNT_W-1:0]    rd_cnt_d, wr_cnt_d, rd_miss_d, wr_miss_d, wb_cnt_d;

  logic [IDX_W-1:0]    set_s1, set_in;
  logic [TAG_W-1:0]    tag_s1;
  logic [NUM_WAYS-1:0] match;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    vic;
  logic [WAY_W-1:0]    vic_nxt;
  logic                vic_dirty;
  logic                miss_wb;
  logic                upd;
  logic [LAT_W-1:0]    lat;

  assign set_s1 = IDX_W'((s1_q.addr >> OFF_W) & ADDR_W'(NUM_SETS - 1));
  assign set_in = IDX_W'((in_data_i.addr >> OFF_W) & ADDR_W'(NUM_SETS - 1));
  assign tag_s1 = TAG_W'(s1_q.addr >> (OFF_W + SET_W));

  always_comb begin
    // a set never written holds no valid line and a zero victim pointer
    row_cur = row_used_q ? row_q : '0;
    match   = '0;
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = row_cur.valid[w] && (row_cur.tags[w] == tag_s1);
    end
    hit = |match;
    // lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    vic       = row_cur.victim;
    vic_dirty = row_cur.dirty[vic];
    vic_nxt   = (vic == WAY_W'(NUM_WAYS - 1)) ? '0 : vic + WAY_W'(1);
    miss_wb   = !hit && vic_dirty;
    upd       = adv && en_q;

    row_new = row_cur;
    if (hit) begin
      if (s1_q.kind) begin
        row_new.dirty[hit_way] = 1'b1;
      end
    end else begin
      row_new.valid[vic] = 1'b1;
      row_new.dirty[vic] = s1_q.kind;
      row_new.tags[vic]  = tag_s1;
      row_new.victim     = vic_nxt;
    end

    if (!en_q) begin
      lat = s1_q.kind ? LAT_W'(wr_lat_q) : LAT_W'(rd_lat_q);
    end else begin
      lat = LAT_W'(hit_lat_q) + (hit ? '0 : LAT_W'(rd_lat_q))
          + (miss_wb ? LAT_W'(wr_lat_q) : '0);
    end

    rd_cnt_d  = rd_cnt_q;
    wr_cnt_d  = wr_cnt_q;
    rd_miss_d = rd_miss_q;
    wr_miss_d = wr_miss_q;
    wb_cnt_d  = wb_cnt_q;
    if (en_q) begin
      if (s1_q.kind) begin
        wr_cnt_d  = wr_cnt_q + CNT_W'(1);
        wr_miss_d = wr_miss_q + CNT_W'(!hit);
      end else begin
        rd_cnt_d  = rd_cnt_q + CNT_W'(1);
        rd_miss_d = rd_miss_q + CNT_W'(!hit);
      end
      wb_cnt_d = wb_cnt_q + CNT_W'(miss_wb);
    end

    out_d.latency            = lat;
    out_d.hit                = en_q && hit;
    out_d.writeback          = en_q && miss_wb;
    out_d.total_reads        = rd_cnt_d;
    out_d.total_writes       = wr_cnt_d;
    out_d.total_read_misses  = rd_miss_d;
    out_d.total_write_misses = wr_miss_d;
    out_d.total_writebacks   = wb_cnt_d;
  end

  // Set memory: forward the row being written to a same-set read
  always_ff @(posedge clk_i) begin
    if (upd) begin
      set_mem[set_s1] <= row_new;
    end
    if (in_acc) begin
      if (upd && (set_in == set_s1)) begin
        row_q <= row_new;
      end else begin
        row_q <= set_mem[set_in];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_used_q <= '0;
      row_used_q <= 1'b0;
      rd_cnt_q   <= '0;
      wr_cnt_q   <= '0;
      rd_miss_q  <= '0;
      wr_miss_q  <= '0;
      wb_cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        row_used_q <= set_used_q[set_in] || (upd && (set_in == set_s1));
      end
      if (upd) begin
        set_used_q[set_s1] <= 1'b1;
        rd_cnt_q  <= rd_cnt_d;
        wr_cnt_q  <= wr_cnt_d;
        rd_miss_q <= rd_miss_d;
        wr_miss_q <= wr_miss_d;
        wb_cnt_q  <= wb_cnt_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.writeback))
    else $error("hit and writeback set on the same beat");

  a_hit_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> (out_q.latency == LAT_W'(hit_lat_q)))
    else $error("hit latency differs from configured value");

  a_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_valid_q) |-> adv)
    else $error("request accepted into an occupied stage");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> (rd_cnt_q + wr_cnt_q) == ($past(rd_cnt_q + wr_cnt_q) + CNT_W'(1)))
    else $error("access counters did not advance by one");

endmodule
